>>> hdl/yapid_pkg.sv
package yapid_pkg;

  localparam int AngleW  = 17;
  localparam int GainW   = 16;
  localparam int SumW    = 32;
  localparam int DriveW  = 32;
  localparam int CfgIdxW = 3;
  localparam int WrapW   = AngleW + 1;
  localparam int MulAW   = GainW + 2;
  localparam int MulBW   = SumW;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = ProdW + 1;
  localparam int FiltShift  = 16;
  localparam int DriveShift = 8;

  localparam logic [GainW-1:0]        WeightReset = 16'd6554;
  localparam logic [MulAW-1:0]        FilterOne   = 18'h10000;
  localparam logic signed [WrapW-1:0] HalfTurn    = 18'sd46080;
  localparam logic signed [WrapW-1:0] NegHalfTurn = -18'sd46080;
  localparam logic signed [WrapW-1:0] FullTurn    = 18'sd92160;

  localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWeight = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_W,
    OP_MUL_S,
    OP_FILT,
    OP_ERR,
    OP_SUM,
    OP_MUL_I,
    OP_MUL_D,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

endpackage

>>> hdl/yaw_angle_pid_with_prefilter_top.sv
// Yaw heading PID with a first-order low-pass prefilter on the measured angle.
// Input channel: in_valid_i / in_stall_o carry one yaw sample (Q.8 degrees).
// Output channel: out_valid_o / out_stall_i carry one drive value per item.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 target, 1 Kp, 2 Ki, 3 Kd, 4 filter weight; other indexes ignored.
//   cfg_ready_o is always high; write only while no item is in flight.
// One shared 18x32 multiplier, stepped by a controller, forms two filter
//   products and the three PID terms in turn. The controller steps through
//   S_MUL_S, S_FILT, S_ERR, S_SUM, S_MUL_I, S_MUL_D and S_OUT before the drive
//   value is registered; a new item is accepted only once it is back in idle.
// The result sits in an output register; the next item is taken while it
//   waits. If it is still stalled when the next result is ready, the datapath
//   holds in its last step and in_stall_o stays high until the register frees.
// Reset clears the controller, filter state, integral, previous error and the
//   config registers but the filter weight, which resets to 6554 (about 0.1).
module yaw_angle_pid_with_prefilter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [yapid_pkg::AngleW-1:0] yaw_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [yapid_pkg::DriveW-1:0] drive_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [yapid_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [yapid_pkg::AngleW-1:0]        cfg_data_i
);
  import yapid_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  yapid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  yapid_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .yaw_sample_i  (yaw_sample_i),
    .drive_value_o (drive_value_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("controller not busy after taking an item");

  a_load_only_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_stall_o)
    else $error("sample loaded while busy");

  a_result_on_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("returned to idle without a result");

  a_rise_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

endmodule

>>> hdl/yapid_ctrl.sv
module yapid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output yapid_pkg::cmd_t cmd_o
);
  import yapid_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_S = 3'd1;
  localparam logic [2:0] S_FILT  = 3'd2;
  localparam logic [2:0] S_ERR   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_MUL_I = 3'd5;
  localparam logic [2:0] S_MUL_D = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '{load: 1'b0, op: OP_NONE};
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = '{load: 1'b1, op: OP_MUL_W};
          state_d = S_MUL_S;
        end
      end
      S_MUL_S: begin
        cmd_o.op = OP_MUL_S;
        state_d  = S_FILT;
      end
      S_FILT: begin
        cmd_o.op = OP_FILT;
        state_d  = S_ERR;
      end
      S_ERR: begin
        cmd_o.op = OP_ERR;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.op = OP_MUL_I;
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/yapid_dp.sv
module yapid_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  yapid_pkg::cmd_t                       cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [yapid_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [yapid_pkg::AngleW-1:0]          cfg_data_i,
  input  logic signed [yapid_pkg::AngleW-1:0]   yaw_sample_i,
  output logic signed [yapid_pkg::DriveW-1:0]   drive_value_o
);
  import yapid_pkg::*;

  logic signed [AngleW-1:0] target_q;
  logic [GainW-1:0]         kp_q, ki_q, kd_q, weight_q;

  logic signed [AngleW-1:0] sample_q;
  logic signed [AngleW-1:0] filt_q, filt_d;
  logic signed [AngleW-1:0] err_q, err_d;
  logic signed [AngleW-1:0] prev_q;
  logic signed [WrapW-1:0]  diff_q, diff_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [ProdW-1:0]  prod_q, prod;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [DriveW-1:0] drive_q, drive_d;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [AccW-1:0]   prod_ext, acc_sum;
  logic signed [WrapW-1:0]  err_raw, err_wrap1, err_wrap2;
  logic signed [SumW:0]     sum_wide;
  logic signed [AccW-DriveShift-1:0] drive_wide;
  logic [AccW-DriveW-DriveShift:0]   drive_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      weight_q <= WeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTarget: target_q <= cfg_data_i;
        RegGainP:  kp_q     <= cfg_data_i[GainW-1:0];
        RegGainI:  ki_q     <= cfg_data_i[GainW-1:0];
        RegGainD:  kd_q     <= cfg_data_i[GainW-1:0];
        RegWeight: weight_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_W: begin
        mul_a = signed'({2'b00, weight_q});
        mul_b = MulBW'(filt_q);
      end
      OP_MUL_S: begin
        mul_a = signed'(FilterOne - {2'b00, weight_q});
        mul_b = MulBW'(sample_q);
      end
      OP_SUM: begin
        mul_a = signed'({2'b00, kp_q});
        mul_b = MulBW'(err_q);
      end
      OP_MUL_I: begin
        mul_a = signed'({2'b00, ki_q});
        mul_b = sum_q;
      end
      OP_MUL_D: begin
        mul_a = signed'({2'b00, kd_q});
        mul_b = MulBW'(diff_q);
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = AccW'(prod_q);
  assign acc_sum  = acc_q + prod_ext;

  assign err_raw   = WrapW'(target_q) - WrapW'(filt_q);
  assign err_wrap1 = (err_raw > HalfTurn) ? err_raw - FullTurn : err_raw;
  assign err_wrap2 = (err_wrap1 < NegHalfTurn) ? err_wrap1 + FullTurn : err_wrap1;

  assign sum_wide   = (SumW+1)'(sum_q) + (SumW+1)'(err_q);
  assign drive_wide = acc_sum[AccW-1:DriveShift];
  assign drive_hi   = acc_sum[AccW-1:DriveW+DriveShift-1];

  always_comb begin
    filt_d  = filt_q;
    err_d   = err_q;
    diff_d  = diff_q;
    sum_d   = sum_q;
    acc_d   = acc_q;
    drive_d = drive_q;
    unique case (cmd_i.op)
      OP_MUL_S, OP_MUL_I: acc_d = prod_ext;
      OP_MUL_D:           acc_d = acc_sum;
      OP_FILT:            filt_d = acc_sum[AngleW+FiltShift-1:FiltShift];
      OP_ERR:             err_d = err_wrap2[AngleW-1:0];
      OP_SUM: begin
        diff_d = WrapW'(err_q) - WrapW'(prev_q);
        if (sum_wide[SumW] != sum_wide[SumW-1]) begin
          sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
          sum_d = sum_wide[SumW-1:0];
        end
      end
      OP_OUT: begin
        if (!(&drive_hi) && (|drive_hi)) begin
          drive_d = drive_hi[AccW-DriveW-DriveShift] ? {1'b1, {(DriveW-1){1'b0}}}
                                                    : {1'b0, {(DriveW-1){1'b1}}};
        end else begin
          drive_d = drive_wide[DriveW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      filt_q <= filt_d;
      sum_q  <= sum_d;
      if (cmd_i.op == OP_SUM) begin
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= yaw_sample_i;
    end
    if (cmd_i.op != OP_NONE) begin
      prod_q <= prod;
    end
    acc_q   <= acc_d;
    err_q   <= err_d;
    diff_q  <= diff_d;
    drive_q <= drive_d;
  end

  assign drive_value_o = drive_q;

endmodule

>>> sim/yapid_checker.sv
module yapid_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [yapid_pkg::AngleW-1:0] yaw_sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [yapid_pkg::DriveW-1:0] drive_value_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [yapid_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [yapid_pkg::AngleW-1:0]        cfg_data_i,
  output int unsigned                         pending_o,
  output int unsigned                         fail_count_o
);
  import yapid_pkg::*;

  logic signed [AngleW-1:0] target_q;
  logic [GainW-1:0]         kp_q;
  logic [GainW-1:0]         ki_q;
  logic [GainW-1:0]         kd_q;
  logic [GainW-1:0]         weight_q;

  logic signed [AngleW-1:0] filt_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [AngleW-1:0] prev_err_q;

  logic signed [DriveW-1:0] drive_q[$];
  int unsigned              failures = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_drive(input logic signed [AngleW-1:0] sample,
                               output logic signed [DriveW-1:0] drive);
    longint mix;
    longint err;
    longint total;
    mix = longint'(weight_q) * longint'(filt_q)
        + (longint'(FilterOne) - longint'(weight_q)) * longint'(sample);
    filt_q = AngleW'(mix >>> FiltShift);
    err = longint'(target_q) - longint'(filt_q);
    if (err > longint'(HalfTurn)) err -= longint'(FullTurn);
    if (err < longint'(NegHalfTurn)) err += longint'(FullTurn);
    sum_q = clamp32(longint'(sum_q) + err);
    total = longint'(kp_q) * err
          + longint'(ki_q) * longint'(sum_q)
          + longint'(kd_q) * (err - longint'(prev_err_q));
    drive = clamp32(total >>> DriveShift);
    prev_err_q = AngleW'(err);
  endtask

  task automatic report_mismatch(input string what, input logic signed [DriveW-1:0] want,
                                 input logic signed [DriveW-1:0] got);
    $display("yapid_checker: %s: expected %0d, got %0d at %0t", what, want, got, $time);
    failures++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DriveW-1:0] want;
    if (!rst_ni) begin
      target_q   = '0;
      kp_q       = '0;
      ki_q       = '0;
      kd_q       = '0;
      weight_q   = WeightReset;
      filt_q     = '0;
      sum_q      = '0;
      prev_err_q = '0;
      drive_q.delete();
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch("drive value with no item pending", '0, drive_value_i);
        end else begin
          want = drive_q.pop_front();
          if (drive_value_i !== want) report_mismatch("drive_value", want, drive_value_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTarget: target_q = cfg_data_i;
          RegGainP:  kp_q = cfg_data_i[GainW-1:0];
          RegGainI:  ki_q = cfg_data_i[GainW-1:0];
          RegGainD:  kd_q = cfg_data_i[GainW-1:0];
          RegWeight: weight_q = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_drive(yaw_sample_i, want);
        drive_q.push_back(want);
      end
      pending_o    <= drive_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import yapid_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned JamCycles  = 300;
  localparam logic signed [AngleW-1:0] AngleMax = 17'sh0FFFF;
  localparam logic signed [AngleW-1:0] AngleMin = 17'sh10000;
  localparam logic signed [AngleW-1:0] HalfAngle = 17'sd46080;

  typedef enum int {
    SWEEP_ANY,
    SWEEP_SPAN,
    SWEEP_NEAR,
    SWEEP_PUSH,
    SWEEP_EDGE
  } sample_mode_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [AngleW-1:0] yaw_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DriveW-1:0] drive_value;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [AngleW-1:0]        cfg_data = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet = 0;
  bit          calm = 1'b0;
  bit          jam_armed = 1'b0;

  always #5 clk = ~clk;

  yaw_angle_pid_with_prefilter_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .yaw_sample_i (yaw_sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .drive_value_o(drive_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  yapid_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .yaw_sample_i (yaw_sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .drive_value_i(drive_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'd256;
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return WeightReset;
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic logic signed [AngleW-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return HalfAngle;
      1: return -HalfAngle;
      2: return AngleW'($urandom);
      default: return AngleW'(int'($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  function automatic logic signed [AngleW-1:0] pick_sample(input sample_mode_e mode,
                                                          input logic signed [AngleW-1:0] aim,
                                                          input int push_dir);
    case (mode)
      SWEEP_ANY:  return AngleW'($urandom);
      SWEEP_SPAN: return AngleW'(int'($urandom_range(0, 92160)) - 46080);
      SWEEP_NEAR: return AngleW'(int'(aim) + int'($urandom_range(0, 4000)) - 2000);
      SWEEP_PUSH: return AngleW'(int'(aim) - push_dir * int'($urandom_range(30000, 46080)));
      default: begin
        case ($urandom_range(0, 5))
          0: return AngleMax;
          1: return AngleMin;
          2: return HalfAngle;
          3: return -HalfAngle;
          4: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [AngleW-1:0] s);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    yaw_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [AngleW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic signed [AngleW-1:0] target,
                            input logic [GainW-1:0] kp, ki, kd, weight);
    drain();
    cfg_write(RegTarget, target);
    cfg_write(RegGainP, {1'($urandom), kp});
    cfg_write(RegGainI, {1'($urandom), ki});
    cfg_write(RegGainD, {1'($urandom), kd});
    cfg_write(RegWeight, {1'($urandom), weight});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned              sent;
    int unsigned              len;
    sample_mode_e             mode;
    int                       push_dir;
    logic signed [AngleW-1:0] aim;
    sent = 0;
    while (sent < count) begin
      aim = pick_target();
      set_config(aim, pick_gain(), pick_gain(), pick_gain(), pick_weight());
      len      = $urandom_range(20, 80);
      mode     = sample_mode_e'($urandom_range(SWEEP_ANY, SWEEP_EDGE));
      push_dir = $urandom_range(0, 1) ? 1 : -1;
      repeat (len) send_sample(pick_sample(mode, aim, push_dir));
      sent += len;
    end
  endtask

  // receiver: random stalls, one long hold-off once armed
  initial begin
    int unsigned jam_delay;
    int unsigned jam_left;
    jam_delay = $urandom_range(20, 200);
    jam_left  = JamCycles;
    forever begin
      @(posedge clk);
      if (jam_armed && jam_delay > 0) jam_delay--;
      if (jam_armed && jam_delay == 0 && jam_left > 0) begin
        jam_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(HalfAngle);
    send_sample(-HalfAngle);

    set_config('0, 16'd256, '0, '0, '0);
    @(posedge clk);
    for (int i = RegWeight + 1; i < 2 ** CfgIdxW; i++) cfg_write(CfgIdxW'(i), AngleW'($urandom));
    cfg_valid <= 1'b0;
    send_sample(HalfAngle);
    send_sample(-HalfAngle);
    send_sample(HalfAngle + 17'sd1);
    send_sample(-HalfAngle - 17'sd1);
    send_sample('0);

    set_config(HalfAngle, '1, '1, '1, '0);
    send_sample(AngleMin);
    send_sample(AngleMax);
    send_sample(-HalfAngle);

    set_config(-HalfAngle, '1, '1, '1, '1);
    send_sample(AngleMax);
    send_sample(AngleMin);
    send_sample('0);

    set_config(AngleMax, 16'h8000, 16'd1, '1, 16'h8000);
    send_sample(AngleMin);
    send_sample('1);
    send_sample(17'sd1);

    set_config(AngleMin, 16'd1, 16'd256, '0, WeightReset);
    send_sample(AngleMax);
    send_sample('0);

    // drive the integral up so that the output clips high, with the long hold-off in it
    set_config('0, pick_gain(), '1, pick_gain(), GainW'($urandom_range(0, 16384)));
    jam_armed = 1'b1;
    repeat (300) send_sample(pick_sample(SWEEP_PUSH, '0, 1));

    run_random(250);

    // push the integral down, no idling on either side
    set_config('0, pick_gain(), pick_gain(), pick_gain(), '0);
    calm = 1'b1;
    repeat (100) send_sample(AngleW'($urandom_range(45000, 46080)));
    calm = 1'b0;

    run_random(100);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
